@@ sv/burst_capture_phase_forwarder_defines.svh @@
// Assertion macros shared by the checker of the burst capture block.
// Needs nothing but a clock and reset name handed in by the user.
`ifndef BURST_CAPTURE_PHASE_FORWARDER_DEFINES_SVH
`define BURST_CAPTURE_PHASE_FORWARDER_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define BCPF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication checked even during reset.
`define BCPF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ sv/bcpf_pkg.sv @@
// Package for the burst capture phase forwarder: sizes, mode codes, CORDIC table.
// Used by both CORDIC pipelines, the top level and the checker; depends on nothing.
package bcpf_pkg;
  localparam int MAX_PACKET_DEF = 1024;
  localparam int PHASE_BITS_DEF = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PKT_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MISS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY     = 3'd5;

  localparam logic [1:0] MODE_LISTEN  = 2'd0;
  localparam logic [1:0] MODE_RECORD  = 2'd1;
  localparam logic [1:0] MODE_FORWARD = 2'd2;
  localparam logic [1:0] MODE_WAIT    = 2'd3;

  localparam logic signed [35:0] GAIN_Q30 = 36'sd652032874;

  function automatic logic [31:0] atan_turns(input int k);
    logic [31:0] t;
    case (k)
      0: t = 32'h20000000;  1: t = 32'h12E4051D;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2E; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
      15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
      21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

  typedef struct packed {
    logic signed [15:0] sample_i;
    logic signed [15:0] sample_q;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] out_i;
    logic signed [15:0] out_q;
    logic               start_of_burst;
    logic               end_of_burst;
    logic [47:0]        tx_time;
  } result_t;
endpackage

@@ sv/bcpf_stream_if.sv @@
// Valid/ready stream interface carrying a payload of generic type.
// Depends on nothing.
interface bcpf_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/bcpf_phase_cordic.sv @@
// Pipelined CORDIC vectoring: sample to phase, one stage per iteration.
// Uses bcpf_pkg for the arctangent table.
module bcpf_phase_cordic #(
  parameter int PHASE_BITS = bcpf_pkg::PHASE_BITS_DEF,
  parameter int TAG_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [15:0]    in_i,
  input  logic signed [15:0]    in_q,
  input  logic [TAG_W-1:0]      in_tag,
  output logic                  out_valid,
  output logic [PHASE_BITS-1:0] out_phase,
  output logic [TAG_W-1:0]      out_tag
);
  localparam int N = bcpf_pkg::CORDIC_STEPS;
  localparam int XW = 30;

  logic signed [XW-1:0] x [N+1];
  logic signed [XW-1:0] y [N+1];
  logic [31:0]          z [N+1];
  logic [TAG_W-1:0]     tag [N+1];
  logic                 vld [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    tag[0] <= in_tag;
    if (in_i < 0) begin
      x[0] <= -(XW'(in_i) <<< 8);
      y[0] <= -(XW'(in_q) <<< 8);
      z[0] <= 32'h80000000;
    end else begin
      x[0] <= XW'(in_i) <<< 8;
      y[0] <= XW'(in_q) <<< 8;
      z[0] <= 32'h0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      tag[k+1] <= tag[k];
      if (y[k] >= 0) begin
        x[k+1] <= x[k] + (y[k] >>> k);
        y[k+1] <= y[k] - (x[k] >>> k);
        z[k+1] <= z[k] + bcpf_pkg::atan_turns(k);
      end else begin
        x[k+1] <= x[k] - (y[k] >>> k);
        y[k+1] <= y[k] + (x[k] >>> k);
        z[k+1] <= z[k] - bcpf_pkg::atan_turns(k);
      end
    end
  end

  logic [31:0] zr;
  assign zr        = z[N] + (32'h1 << (31 - PHASE_BITS));
  assign out_phase = zr[31 -: PHASE_BITS];
  assign out_valid = vld[N];
  assign out_tag   = tag[N];
endmodule

@@ sv/bcpf_unit_cordic.sv @@
// Pipelined CORDIC rotation: stored phase to a Q1.14 unit vector.
// Uses bcpf_pkg for the gain constant, table and result type.
module bcpf_unit_cordic #(
  parameter int PHASE_BITS = bcpf_pkg::PHASE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [PHASE_BITS-1:0]   in_phase,
  input  bcpf_pkg::result_t       in_meta,
  output logic                    out_valid,
  output bcpf_pkg::result_t       out_res
);
  localparam int N = bcpf_pkg::CORDIC_STEPS;
  localparam int XW = 36;

  logic signed [XW-1:0] x [N+1];
  logic signed [XW-1:0] y [N+1];
  logic signed [32:0]   a [N+1];
  logic                 flip [N+1];
  logic                 vld [N+1];
  bcpf_pkg::result_t    meta [N+1];

  logic [31:0] zw;
  logic [31:0] zf;
  logic        fl;
  always_comb begin
    zw = {in_phase, {(32-PHASE_BITS){1'b0}}};
    fl = (zw[31:30] == 2'd1) || (zw[31:30] == 2'd2);
    zf = fl ? zw + 32'h80000000 : zw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    meta[0] <= in_meta;
    flip[0] <= fl;
    x[0]    <= bcpf_pkg::GAIN_Q30;
    y[0]    <= '0;
    a[0]    <= 33'(signed'(zf));
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      meta[k+1] <= meta[k];
      flip[k+1] <= flip[k];
      if (a[k] >= 0) begin
        x[k+1] <= x[k] - (y[k] >>> k);
        y[k+1] <= y[k] + (x[k] >>> k);
        a[k+1] <= a[k] - 33'(bcpf_pkg::atan_turns(k));
      end else begin
        x[k+1] <= x[k] + (y[k] >>> k);
        y[k+1] <= y[k] - (x[k] >>> k);
        a[k+1] <= a[k] + 33'(bcpf_pkg::atan_turns(k));
      end
    end
  end

  function automatic logic signed [15:0] to_q14(input logic signed [XW-1:0] v, input logic neg);
    logic signed [XW-1:0] r;
    logic signed [15:0]   c;
    r = (v + XW'(32768)) >>> 16;
    if (r > XW'(16384)) c = 16'sd16384;
    else if (r < -XW'(16384)) c = -16'sd16384;
    else c = r[15:0];
    return neg ? -c : c;
  endfunction

  always_comb begin
    out_res       = meta[N];
    out_res.out_i = to_q14(x[N], flip[N]);
    out_res.out_q = to_q14(y[N], flip[N]);
  end
  assign out_valid = vld[N];
endmodule

@@ sv/burst_capture_phase_forwarder.sv @@
// Top level of the burst capture phase forwarder.
// Uses bcpf_pkg, bcpf_stream_if and both CORDIC pipelines.

// One sample is accepted per clock whenever the result path has credit; with a
// sink that is always ready the input never stalls. The mode control handles
// each sample in the cycle it is accepted. A recorded sample's phase comes out
// of a 25-stage vectoring CORDIC and is then written to the phase memory. Each
// forwarded sample first waits in a read delay line as long as the phase
// pipeline, so its memory read always comes after the write of the entry it
// needs, then reads the registered memory and passes a 25-stage rotation CORDIC
// and a result FIFO. Up to 64 results may be outstanding. While the sink stalls
// the 64-entry FIFO absorbs them, and the input stalls once that credit is used
// up.
module burst_capture_phase_forwarder #(
  parameter int MAX_PACKET = bcpf_pkg::MAX_PACKET_DEF,
  parameter int PHASE_BITS = bcpf_pkg::PHASE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bcpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcpf_pkg::CFG_DATA_W-1:0]   cfg_data,
  bcpf_stream_if.sink                       samples,
  bcpf_stream_if.source                     results
);
  localparam int AW = $clog2(MAX_PACKET);
  localparam int CW = $clog2(MAX_PACKET + 1) + 1;
  localparam int RD = bcpf_pkg::CORDIC_STEPS + 1;
  localparam int FD = 64;
  localparam int FA = $clog2(FD);
  localparam int IW = $clog2(FD + 1);

  logic [31:0] min_level_sq, max_level_sq, delay_samples;
  logic [10:0] pkt_len;
  logic [9:0]  max_missed;
  logic [23:0] wait_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level_sq  <= '0;
      max_level_sq  <= 32'h80000000;
      pkt_len       <= 11'd1024;
      max_missed    <= 10'd8;
      wait_samples  <= 24'd1000;
      delay_samples <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bcpf_pkg::REG_MIN_LEVEL: min_level_sq  <= cfg_data;
        bcpf_pkg::REG_MAX_LEVEL: max_level_sq  <= cfg_data;
        bcpf_pkg::REG_PKT_LEN:   pkt_len       <= cfg_data[10:0];
        bcpf_pkg::REG_MAX_MISS:  max_missed    <= cfg_data[9:0];
        bcpf_pkg::REG_WAIT:      wait_samples  <= cfg_data[23:0];
        bcpf_pkg::REG_DELAY:     delay_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CW-1:0] len;
  always_comb begin
    if (pkt_len < 11'd2) len = CW'(2);
    else if (CW'(pkt_len) > CW'(MAX_PACKET)) len = CW'(MAX_PACKET);
    else len = CW'(pkt_len);
  end

  // Credit count: results in flight plus held in the FIFO and the output stage.
  logic [IW-1:0] inflight;
  logic fire, emit, drain;
  assign samples.ready = (inflight < IW'(FD));
  assign fire = samples.valid && samples.ready;

  logic [1:0]    mode;
  logic [CW-1:0] record_count, forward_count;
  logic [9:0]    missed_count;
  logic [23:0]   wait_count;
  logic [47:0]   sample_clock, burst_tx_time;

  logic [31:0] mag;
  logic        hit;
  always_comb begin
    mag = unsigned'(32'(samples.data.sample_i * samples.data.sample_i))
        + unsigned'(32'(samples.data.sample_q * samples.data.sample_q));
    hit = (mag > min_level_sq) && (mag < max_level_sq);
  end

  logic          wr_req;
  logic [AW-1:0] wr_idx;
  logic [CW-1:0] rc_inc, fc_inc;
  assign rc_inc = record_count + CW'(1);
  assign fc_inc = forward_count + CW'(1);

  always_comb begin
    wr_req = 1'b0;
    wr_idx = '0;
    emit   = 1'b0;
    if (fire && mode == bcpf_pkg::MODE_LISTEN && hit) begin
      wr_req = 1'b1;
    end else if (fire && mode == bcpf_pkg::MODE_RECORD && hit &&
                 record_count < CW'(MAX_PACKET)) begin
      wr_req = 1'b1;
      wr_idx = record_count[AW-1:0];
    end
    if (fire && mode == bcpf_pkg::MODE_FORWARD) emit = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= bcpf_pkg::MODE_LISTEN;
      record_count  <= '0;
      forward_count <= '0;
      missed_count  <= '0;
      wait_count    <= '0;
      sample_clock  <= '0;
      burst_tx_time <= '0;
    end else if (fire) begin
      sample_clock <= sample_clock + 48'd1;
      case (mode)
        bcpf_pkg::MODE_LISTEN: begin
          if (hit) begin
            burst_tx_time <= sample_clock + 48'(delay_samples);
            record_count  <= CW'(1);
            missed_count  <= '0;
            mode          <= bcpf_pkg::MODE_RECORD;
          end
        end
        bcpf_pkg::MODE_RECORD: begin
          if (hit) begin
            record_count <= rc_inc;
            if (rc_inc >= len) begin
              forward_count <= '0;
              mode          <= bcpf_pkg::MODE_FORWARD;
            end
          end else if (missed_count >= max_missed) begin
            mode <= bcpf_pkg::MODE_LISTEN;
          end else begin
            missed_count <= missed_count + 10'd1;
          end
        end
        bcpf_pkg::MODE_FORWARD: begin
          forward_count <= fc_inc;
          if (fc_inc >= len) begin
            wait_count <= '0;
            mode       <= bcpf_pkg::MODE_WAIT;
          end
        end
        default: begin
          wait_count <= wait_count + 24'd1;
          if (wait_count + 24'd1 >= wait_samples) mode <= bcpf_pkg::MODE_LISTEN;
        end
      endcase
    end
  end

  // Phase capture pipeline and the phase memory.
  logic                  ph_valid;
  logic [PHASE_BITS-1:0] ph_value;
  logic [AW-1:0]         ph_idx;

  bcpf_phase_cordic #(.PHASE_BITS(PHASE_BITS), .TAG_W(AW)) u_phase (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wr_req),
    .in_i      (samples.data.sample_i),
    .in_q      (samples.data.sample_q),
    .in_tag    (wr_idx),
    .out_valid (ph_valid),
    .out_phase (ph_value),
    .out_tag   (ph_idx)
  );

  logic [PHASE_BITS-1:0] phase_store [MAX_PACKET];
  logic [PHASE_BITS-1:0] rd_phase;
  logic                  rd_valid;
  bcpf_pkg::result_t     rd_meta, meta_next;

  always_comb begin
    meta_next                = '0;
    meta_next.start_of_burst = (forward_count == '0);
    meta_next.end_of_burst   = (fc_inc >= len);
    meta_next.tx_time        = (forward_count == '0) ? burst_tx_time : 48'd0;
  end

  // Read requests wait one phase pipeline length, so the entry a read needs
  // has always been written by the time the read reaches the memory.
  logic              rq_valid [RD];
  logic [AW-1:0]     rq_idx   [RD];
  bcpf_pkg::result_t rq_meta  [RD];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < RD; j++) rq_valid[j] <= 1'b0;
    end else begin
      rq_valid[0] <= emit;
      for (int j = 1; j < RD; j++) rq_valid[j] <= rq_valid[j-1];
    end
    rq_idx[0]  <= forward_count[AW-1:0];
    rq_meta[0] <= meta_next;
    for (int j = 1; j < RD; j++) begin
      rq_idx[j]  <= rq_idx[j-1];
      rq_meta[j] <= rq_meta[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ph_valid) phase_store[ph_idx] <= ph_value;
    rd_phase <= phase_store[rq_idx[RD-1]];
    rd_meta  <= rq_meta[RD-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rq_valid[RD-1];
    end
  end

  logic              uc_valid;
  bcpf_pkg::result_t uc_res;

  bcpf_unit_cordic #(.PHASE_BITS(PHASE_BITS)) u_unit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_phase  (rd_phase),
    .in_meta   (rd_meta),
    .out_valid (uc_valid),
    .out_res   (uc_res)
  );

  // The result FIFO holds every credited result, so it never overflows.
  bcpf_pkg::result_t fifo [FD];
  logic [FA-1:0] wp, rp;
  logic [FA:0]   fcount;
  logic          out_v;
  bcpf_pkg::result_t out_d;

  assign drain = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (uc_valid) fifo[wp] <= uc_res;
    if (!out_v || results.ready) out_d <= fifo[rp];
  end

  logic pop;
  assign pop = (fcount != '0) && (!out_v || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fcount <= '0;
      out_v <= 1'b0;
      inflight <= '0;
    end else begin
      if (uc_valid) wp <= wp + FA'(1);
      if (pop) rp <= rp + FA'(1);
      fcount <= fcount + (FA+1)'(uc_valid) - (FA+1)'(pop);
      if (pop) out_v <= 1'b1;
      else if (results.ready) out_v <= 1'b0;
      inflight <= inflight + IW'(emit) - IW'(drain);
    end
  end

  assign results.valid = out_v;
  assign results.data  = out_d;
endmodule

@@ sv/bcpf_checker.sv @@
// Port-level checker for the burst capture phase forwarder, bound to the top.
// Depends on bcpf_pkg and the assertion macros header.
`include "burst_capture_phase_forwarder_defines.svh"
module bcpf_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input bcpf_pkg::result_t out_data
);
  `BCPF_ASSERT(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
  `BCPF_ASSERT(a_unit, clk, rst, out_valid |-> out_data.out_i <= 16'sd16384 && out_data.out_i >= -16'sd16384, "out_i beyond unit range")
  `BCPF_ASSERT(a_tx, clk, rst, out_valid && !out_data.start_of_burst |-> out_data.tx_time == 48'd0, "tx_time set without start flag")
  `BCPF_ASSERT_ALWAYS(a_rst, clk, rst |=> !out_valid, "result valid right after reset")
endmodule

bind burst_capture_phase_forwarder bcpf_checker u_bcpf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.data)
);
